// ----- sv/stable_multikey_row_sorter_defines.svh -----
// assertion macros shared by the checker of the row sorter
// needs nothing else, each use sits on a line of its own
`ifndef STABLE_MULTIKEY_ROW_SORTER_DEFINES_SVH
`define STABLE_MULTIKEY_ROW_SORTER_DEFINES_SVH

// property checked only while out of reset
`define SMRS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every edge, reset included
`define SMRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/smrs_pkg.sv -----
// shared types, codes and defaults of the row sorter
// used by every module of the block, depends on nothing
package smrs_pkg;

  localparam int CELLS    = 8;
  localparam int CELL_W   = 32;
  localparam int KEY_REGS = 4;

  localparam int MAX_ROWS_DEF    = 64;
  localparam int MAX_COLUMNS_DEF = 8;
  localparam int MAX_KEYS_DEF    = 4;

  // item kinds
  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_EMIT   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // register indexes on the config port
  localparam logic [2:0] REG_COLUMN_COUNT = 3'd0;
  localparam logic [2:0] REG_KEY_COUNT    = 3'd1;
  localparam logic [2:0] REG_KEY_COL_0    = 3'd2;
  localparam logic [2:0] REG_KEY_COL_1    = 3'd3;
  localparam logic [2:0] REG_KEY_COL_2    = 3'd4;
  localparam logic [2:0] REG_KEY_COL_3    = 3'd5;

  typedef logic [CELLS-1:0][CELL_W-1:0] row_t;

  typedef struct packed {
    logic [2:0]                key_num;
    logic [KEY_REGS-1:0][2:0]  key_col;
  } key_cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] in_cell_0;
    logic signed [31:0] in_cell_1;
    logic signed [31:0] in_cell_2;
    logic signed [31:0] in_cell_3;
    logic signed [31:0] in_cell_4;
    logic signed [31:0] in_cell_5;
    logic signed [31:0] in_cell_6;
    logic signed [31:0] in_cell_7;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_cell_0;
    logic signed [31:0] out_cell_1;
    logic signed [31:0] out_cell_2;
    logic signed [31:0] out_cell_3;
    logic signed [31:0] out_cell_4;
    logic signed [31:0] out_cell_5;
    logic signed [31:0] out_cell_6;
    logic signed [31:0] out_cell_7;
    logic               last_row;
    logic               rows_dropped;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_LOAD_T,
    ST_CMP,
    ST_PLACE,
    ST_EMIT
  } smrs_state_t;

endpackage

// ----- sv/smrs_row_mem.sv -----
// row store: one write port and one registered read port
// uses row_t from smrs_pkg
module smrs_row_mem
  import smrs_pkg::*;
#(
  parameter int DEPTH = MAX_ROWS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  row_t                     wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output row_t                     rdata
);

  row_t mem [DEPTH];
  row_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/smrs_key_cmp.sv -----
// shared row comparator: lexicographic signed order on the key columns
// uses row_t and key_cfg_t from smrs_pkg
module smrs_key_cmp
  import smrs_pkg::*;
(
  input  row_t     row_a,
  input  row_t     row_b,
  input  key_cfg_t cfg,
  output logic     a_less
);

  logic              decided;
  logic [CELL_W-1:0] xa;
  logic [CELL_W-1:0] xb;

  // first key column that differs decides, equal rows stay put
  always_comb begin
    decided = 1'b0;
    a_less  = 1'b0;
    xa      = '0;
    xb      = '0;
    for (int k = 0; k < KEY_REGS; k++) begin
      if (!decided && (3'(k) < cfg.key_num)) begin
        xa = row_a[cfg.key_col[k]];
        xb = row_b[cfg.key_col[k]];
        if (xa != xb) begin
          a_less  = $signed(xa) < $signed(xb);
          decided = 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/stable_multikey_row_sorter.sv -----
// Stable multi-key row sorter, top level.
// Holds up to MAX_ROWS rows of eight signed 32-bit cells in a row store.
// Input: in_item is taken when start is high and busy is low.
//   append - stores the row after the held rows; a row that does not fit
//            is dropped and the sticky rows_dropped flag is set
//   clear  - empties the table and clears the flag
//   emit   - insertion-sorts the store in place on the key columns with one
//            shared comparator and one memory port pair, then streams rows
// Output: out_valid marks each row for exactly one cycle, rows of one table
//   come back to back and the final one carries last_row. The receiver
//   cannot stall the block.
// Emit of n rows (n > 1): one load step, then per inserted row a fetch and
//   compares that move rows up until a compare or a final place at slot 0
//   writes it (at most n(n-1)/2 row moves in all), then one emit step per
//   row. A single row skips the sort. The first row shows in the cycle
//   after the first emit step, busy drops as the last row shows.
// Config: APB-style port, registers at 4*index, to be written only while
//   idle; the block itself does not enforce it.
// Reset (rst_n low, synchronous) empties the table, clears the flag and
//   loads the register defaults; row store contents are not cleared.
module stable_multikey_row_sorter
  import smrs_pkg::*;
#(
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_KEYS    = MAX_KEYS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW      = $clog2(MAX_ROWS);
  localparam int CW      = $clog2(MAX_ROWS + 1);
  localparam int KEY_LIM = (MAX_KEYS < KEY_REGS) ? MAX_KEYS : KEY_REGS;

  // config registers
  logic [3:0]               column_count_r;
  logic [2:0]               key_count_r;
  logic [KEY_REGS-1:0][2:0] key_col_r;
  logic                     cfg_write;
  logic [2:0]               cfg_index;

  assign pready    = 1'b1;
  assign cfg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= 4'd8;
      key_count_r    <= 3'd1;
      for (int k = 0; k < KEY_REGS; k++) begin
        key_col_r[k] <= 3'(k);
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COLUMN_COUNT: column_count_r <= pwdata[3:0];
        REG_KEY_COUNT:    key_count_r    <= pwdata[2:0];
        REG_KEY_COL_0:    key_col_r[0]   <= pwdata[2:0];
        REG_KEY_COL_1:    key_col_r[1]   <= pwdata[2:0];
        REG_KEY_COL_2:    key_col_r[2]   <= pwdata[2:0];
        REG_KEY_COL_3:    key_col_r[3]   <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_COLUMN_COUNT: prdata = {28'd0, column_count_r};
      REG_KEY_COUNT:    prdata = {29'd0, key_count_r};
      REG_KEY_COL_0:    prdata = {29'd0, key_col_r[0]};
      REG_KEY_COL_1:    prdata = {29'd0, key_col_r[1]};
      REG_KEY_COL_2:    prdata = {29'd0, key_col_r[2]};
      REG_KEY_COL_3:    prdata = {29'd0, key_col_r[3]};
      default:          prdata = '0;
    endcase
  end

  key_cfg_t key_cfg;

  assign key_cfg.key_num = (key_count_r > 3'(KEY_LIM)) ? 3'(KEY_LIM) : key_count_r;
  assign key_cfg.key_col = key_col_r;

  // incoming row with unused columns zeroed
  row_t in_raw;
  row_t in_row;

  assign in_raw[0] = in_item.in_cell_0;
  assign in_raw[1] = in_item.in_cell_1;
  assign in_raw[2] = in_item.in_cell_2;
  assign in_raw[3] = in_item.in_cell_3;
  assign in_raw[4] = in_item.in_cell_4;
  assign in_raw[5] = in_item.in_cell_5;
  assign in_raw[6] = in_item.in_cell_6;
  assign in_raw[7] = in_item.in_cell_7;

  always_comb begin
    for (int c = 0; c < CELLS; c++) begin
      in_row[c] = ((4'(c) < column_count_r) && (c < MAX_COLUMNS)) ? in_raw[c] : '0;
    end
  end

  // sequencer state
  smrs_state_t   state_r, state_nxt;
  logic [CW-1:0] row_total_r, row_total_nxt;
  logic          overflow_r, overflow_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] k_r, k_nxt;
  row_t          t_r, t_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_last_r, out_last_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  row_t          mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  row_t          mem_rdata;
  logic          t_less;
  logic          pass_done;

  smrs_row_mem #(
    .DEPTH (MAX_ROWS)
  ) u_row_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  smrs_key_cmp u_key_cmp (
    .row_a  (t_r),
    .row_b  (mem_rdata),
    .cfg    (key_cfg),
    .a_less (t_less)
  );

  // the row just placed was the last one to insert
  assign pass_done = (CW'(i_r) + CW'(1)) == row_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_total_r <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_total_r <= row_total_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
    t_r <= t_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    row_total_nxt = row_total_r;
    overflow_nxt  = overflow_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    t_nxt         = t_r;
    out_valid_nxt = 1'b0;
    out_last_nxt  = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = j_r;
    mem_wdata     = t_r;
    mem_re        = 1'b0;
    mem_raddr     = i_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_item.kind)
            KIND_APPEND: begin
              if (row_total_r == CW'(MAX_ROWS)) begin
                overflow_nxt = 1'b1;
              end else begin
                mem_we        = 1'b1;
                mem_waddr     = row_total_r[AW-1:0];
                mem_wdata     = in_row;
                row_total_nxt = row_total_r + 1'b1;
              end
            end
            KIND_EMIT: begin
              if (row_total_r == CW'(1)) begin
                k_nxt     = '0;
                state_nxt = ST_EMIT;
              end else if (row_total_r != '0) begin
                i_nxt     = AW'(1);
                state_nxt = ST_LOAD;
              end
            end
            KIND_CLEAR: begin
              row_total_nxt = '0;
              overflow_nxt  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        mem_re    = 1'b1;
        mem_raddr = i_r;
        state_nxt = ST_LOAD_T;
      end
      ST_LOAD_T: begin
        t_nxt     = mem_rdata;
        j_nxt     = i_r;
        mem_re    = 1'b1;
        mem_raddr = i_r - AW'(1);
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        if (t_less) begin
          // shift the larger row up one slot
          mem_wdata = mem_rdata;
          j_nxt     = j_r - AW'(1);
          if (j_r == AW'(1)) begin
            state_nxt = ST_PLACE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = j_r - AW'(2);
          end
        end else begin
          mem_wdata = t_r;
          if (pass_done) begin
            k_nxt     = '0;
            state_nxt = ST_EMIT;
          end else begin
            i_nxt     = i_r + AW'(1);
            mem_re    = 1'b1;
            mem_raddr = i_r + AW'(1);
            state_nxt = ST_LOAD_T;
          end
        end
      end
      ST_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = t_r;
        if (pass_done) begin
          k_nxt     = '0;
          state_nxt = ST_EMIT;
        end else begin
          i_nxt     = i_r + AW'(1);
          mem_re    = 1'b1;
          mem_raddr = i_r + AW'(1);
          state_nxt = ST_LOAD_T;
        end
      end
      ST_EMIT: begin
        mem_re        = 1'b1;
        mem_raddr     = k_r;
        out_valid_nxt = 1'b1;
        out_last_nxt  = (CW'(k_r) + CW'(1)) == row_total_r;
        k_nxt         = k_r + AW'(1);
        if (out_last_nxt) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    out_item.out_cell_0   = mem_rdata[0];
    out_item.out_cell_1   = mem_rdata[1];
    out_item.out_cell_2   = mem_rdata[2];
    out_item.out_cell_3   = mem_rdata[3];
    out_item.out_cell_4   = mem_rdata[4];
    out_item.out_cell_5   = mem_rdata[5];
    out_item.out_cell_6   = mem_rdata[6];
    out_item.out_cell_7   = mem_rdata[7];
    out_item.last_row     = out_last_r;
    out_item.rows_dropped = overflow_r;
  end

endmodule

// ----- sv/smrs_check.sv -----
// port-level checker of the row sorter, bound to the top level
// uses smrs_pkg types and the assertion macros of the defines header
`include "stable_multikey_row_sorter_defines.svh"

module smrs_check
  import smrs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  // reset leaves the block idle with no row on the output
  `SMRS_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (!busy && !out_valid), "not idle after reset")

  // a row only follows a busy cycle
  `SMRS_ASSERT(a_row_after_busy, clk, rst_n, out_valid |-> $past(busy), "row without emit")

  // rows of one table come back to back until the last one
  `SMRS_ASSERT(a_rows_gapless, clk, rst_n, (out_valid && !out_item.last_row) |=> out_valid, "gap in table")

  // neither an accepted transfer nor the last row of a table is followed by a row in the next cycle
  `SMRS_ASSERT(a_no_early_row, clk, rst_n, ((start && !busy) || (out_valid && out_item.last_row)) |=> !out_valid, "row too early")

endmodule

bind stable_multikey_row_sorter smrs_check u_smrs_check (.*);

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// testbench of the stable multi-key row sorter: tables of rows are appended, sorted and
// emitted under many key settings, every emitted row is checked against a local predictor
// depends on smrs_pkg and the stable_multikey_row_sorter top level
module tb_top;
  import smrs_pkg::*;

  localparam int          TABLE_ROWS   = MAX_ROWS_DEF;
  localparam int          USED_COLS    = MAX_COLUMNS_DEF;
  localparam int          USED_KEYS    = (MAX_KEYS_DEF < KEY_REGS) ? MAX_KEYS_DEF : KEY_REGS;
  localparam logic [1:0]  KIND_IGNORED = 2'd3;
  localparam logic [31:0] CELL_NULL    = 32'h7fff_ffff;
  localparam logic [31:0] CELL_MIN     = 32'h8000_0000;
  localparam int          COL_EXTREMES [4] = '{0, 1, 8, 15};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predicted table and register state
  row_t        table_rows [TABLE_ROWS];
  int          table_count;
  bit          table_overflow;
  logic [3:0]  col_count_reg;
  logic [2:0]  key_count_reg;
  logic [2:0]  key_col_reg [KEY_REGS];
  out_item_t   expected_rows [$];
  int          error_count;
  int          sent_count;
  bit          gaps_off;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  stable_multikey_row_sorter u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  function automatic row_t cells_of_input(in_item_t it);
    return {it.in_cell_7, it.in_cell_6, it.in_cell_5, it.in_cell_4,
            it.in_cell_3, it.in_cell_2, it.in_cell_1, it.in_cell_0};
  endfunction

  function automatic row_t cells_of_result(out_item_t o);
    return {o.out_cell_7, o.out_cell_6, o.out_cell_5, o.out_cell_4,
            o.out_cell_3, o.out_cell_2, o.out_cell_1, o.out_cell_0};
  endfunction

  function automatic in_item_t row_item(logic [1:0] kind, row_t r);
    return {kind, r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7]};
  endfunction

  // signed compare on the active keys, ties keep the earlier row first
  function automatic bit row_precedes(row_t a, row_t b);
    int         nkeys;
    logic [2:0] col;
    nkeys = (key_count_reg > USED_KEYS) ? USED_KEYS : key_count_reg;
    for (int k = 0; k < nkeys; k++) begin
      col = key_col_reg[k];
      if (a[col] != b[col])
        return $signed(a[col]) < $signed(b[col]);
    end
    return 1'b0;
  endfunction

  function automatic void sort_table();
    row_t held;
    int   j;
    for (int i = 1; i < table_count; i++) begin
      held = table_rows[i];
      j = i;
      while (j > 0 && row_precedes(held, table_rows[j-1])) begin
        table_rows[j] = table_rows[j-1];
        j--;
      end
      table_rows[j] = held;
    end
  endfunction

  function automatic void predict_item(in_item_t it);
    row_t      r;
    int        ncols;
    bit        last;
    out_item_t o;
    case (it.kind)
      KIND_APPEND: begin
        if (table_count >= TABLE_ROWS) begin
          table_overflow = 1'b1;
        end else begin
          ncols = (col_count_reg > USED_COLS) ? USED_COLS : col_count_reg;
          r = cells_of_input(it);
          for (int c = 0; c < CELLS; c++)
            if (c >= ncols) r[c] = '0;
          table_rows[table_count] = r;
          table_count++;
        end
      end
      KIND_CLEAR: begin
        table_count = 0;
        table_overflow = 1'b0;
      end
      KIND_EMIT: begin
        sort_table();
        for (int i = 0; i < table_count; i++) begin
          r = table_rows[i];
          last = (i == table_count - 1);
          o = {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], last, table_overflow};
          expected_rows = {expected_rows, o};
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] random_cell();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return int'($urandom_range(0, 4)) - 2;
      5: begin
        case ($urandom_range(0, 3))
          0:       return CELL_MIN;
          1:       return CELL_NULL;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic row_t random_row();
    row_t r;
    for (int c = 0; c < CELLS; c++)
      r[c] = random_cell();
    return r;
  endfunction

  // one transfer on the input channel, start stays high into the next item
  task automatic send_item(in_item_t it);
    int gap;
    if (!gaps_off && $urandom_range(0, 9) == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    predict_item(it);
    if (it.kind != KIND_IGNORED) sent_count++;
  endtask

  task automatic send_kind(logic [1:0] kind);
    send_item(row_item(kind, random_row()));
  endtask

  // hold the sender until every row is back and the block is idle
  task automatic drain_results();
    start <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_COLUMN_COUNT: col_count_reg = value[3:0];
      REG_KEY_COUNT:    key_count_reg = value[2:0];
      REG_KEY_COL_0:    key_col_reg[0] = value[2:0];
      REG_KEY_COL_1:    key_col_reg[1] = value[2:0];
      REG_KEY_COL_2:    key_col_reg[2] = value[2:0];
      REG_KEY_COL_3:    key_col_reg[3] = value[2:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int cols, int keys, int k0, int k1, int k2, int k3);
    drain_results();
    write_reg(REG_COLUMN_COUNT, 32'(cols));
    write_reg(REG_KEY_COUNT,    32'(keys));
    write_reg(REG_KEY_COL_0,    32'(k0));
    write_reg(REG_KEY_COL_1,    32'(k1));
    write_reg(REG_KEY_COL_2,    32'(k2));
    write_reg(REG_KEY_COL_3,    32'(k3));
  endtask

  task automatic random_config();
    int cols;
    cols = ($urandom_range(0, 4) == 0) ? COL_EXTREMES[$urandom_range(0, 3)]
                                       : $urandom_range(0, 15);
    set_config(cols, $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7),
               $urandom_range(0, 7), $urandom_range(0, 7));
  endtask

  task automatic test_reset_defaults();
    row_t r;
    send_kind(KIND_EMIT);      // empty table, nothing comes back
    send_kind(KIND_IGNORED);
    // extremes in the first key column, two rows tie on the minimum
    r = random_row(); r[0] = CELL_NULL;                  send_item(row_item(KIND_APPEND, r));
    r = random_row(); r[0] = CELL_MIN;  r[1] = 32'd1;    send_item(row_item(KIND_APPEND, r));
    r = random_row(); r[0] = '0;                         send_item(row_item(KIND_APPEND, r));
    r = random_row(); r[0] = CELL_MIN;  r[1] = '1;       send_item(row_item(KIND_APPEND, r));
    r = random_row(); r[0] = '1;                         send_item(row_item(KIND_APPEND, r));
    send_kind(KIND_EMIT);
    drain_results();
    send_kind(KIND_EMIT);      // stored order is already sorted
    send_kind(KIND_CLEAR);
    send_kind(KIND_EMIT);
  endtask

  // each step re-sorts the rows collected so far under new keys
  task automatic test_register_sweep();
    int sweep [4][6] = '{'{0, 4, 7, 6, 5, 4},
                         '{15, 7, 3, 3, 0, 7},
                         '{1, 0, 0, 1, 2, 3},
                         '{5, 2, 6, 1, 4, 2}};
    foreach (sweep[s]) begin
      set_config(sweep[s][0], sweep[s][1], sweep[s][2], sweep[s][3], sweep[s][4],
                 sweep[s][5]);
      send_kind(KIND_APPEND);
      send_kind(KIND_APPEND);
      send_kind(KIND_EMIT);
    end
  endtask

  task automatic test_random_tables(int count);
    int target;
    int tables;
    int nrows;
    target = sent_count + count;
    tables = 0;
    while (sent_count < target) begin
      if (tables % 3 == 0) random_config();
      gaps_off = (tables >= 8 && tables < 14);
      if ($urandom_range(0, 9) < 7) send_kind(KIND_CLEAR);
      nrows = ($urandom_range(0, 9) == 0) ? $urandom_range(TABLE_ROWS - 4, TABLE_ROWS + 6)
                                          : $urandom_range(1, 12);
      for (int i = 0; i < nrows; i++) begin
        // occasional noise breaks the table apart
        case ($urandom_range(0, 39))
          0: send_kind(KIND_IGNORED);
          1: send_kind(KIND_EMIT);
          2: send_kind(KIND_CLEAR);
          default: ;
        endcase
        send_kind(KIND_APPEND);
      end
      send_kind(KIND_EMIT);
      tables++;
    end
    gaps_off = 1'b0;
  endtask

  always @(posedge clk) begin : check_rows
    out_item_t want;
    row_t      want_cells;
    row_t      got_cells;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected row transfer, expected none, got %h", $time, out_item);
        error_count++;
      end else begin
        want = expected_rows.pop_front();
        want_cells = cells_of_result(want);
        got_cells  = cells_of_result(out_item);
        for (int c = 0; c < CELLS; c++)
          if (got_cells[c] !== want_cells[c]) begin
            $display("%0t: out_cell_%0d expected %0d got %0d", $time, c,
                     $signed(want_cells[c]), $signed(got_cells[c]));
            error_count++;
          end
        if (out_item.last_row !== want.last_row) begin
          $display("%0t: last_row expected %b got %b", $time, want.last_row,
                   out_item.last_row);
          error_count++;
        end
        if (out_item.rows_dropped !== want.rows_dropped) begin
          $display("%0t: rows_dropped expected %b got %b", $time, want.rows_dropped,
                   out_item.rows_dropped);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    table_count    = 0;
    table_overflow = 1'b0;
    col_count_reg  = 4'd8;
    key_count_reg  = 3'd1;
    key_col_reg    = '{3'd0, 3'd1, 3'd2, 3'd3};
    error_count    = 0;
    sent_count     = 0;
    gaps_off       = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_register_sweep();
    test_random_tables(400);
    drain_results();
    repeat (50) @(posedge clk);
    if (error_count == 0 && expected_rows.size() == 0)
      $display("[stable_multikey_row_sorter] OK");
    else
      $display("[stable_multikey_row_sorter] ERROR");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("[stable_multikey_row_sorter] ERROR");
    $finish;
  end

endmodule
